// File: src/hcm_pkg.sv
// shared types and character constants for the host canonicalizer and matcher
// no dependencies; used by the controller, datapath and top level

package hcm_pkg;

    // controller states
    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_EVAL = 1'b1
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;   // request taken this cycle: latch it, launch store reads
        logic commit;   // result goes to output register, string state updates
    } t_dp_cmd;

    // request kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // characters of interest
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;

    // saturation points of the string counters
    localparam logic [8:0] COUNT_SAT = 9'd511;
    localparam logic [7:0] INDEX_SAT = 8'd255;

    // stream payload widths
    localparam int TDATA_W = 16;

endpackage

// File: src/hcm_ctrl.sv
// controller: accept / evaluate sequencing and output register occupancy
// depends on hcm_pkg

module hcm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output hcm_pkg::t_dp_cmd  o_cmd
);

    hcm_pkg::t_state r_state, n_state;
    logic            r_out_vld, n_out_vld;

    // state and output-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= hcm_pkg::ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    // next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd.accept = 1'b0;
        o_cmd.commit = 1'b0;
        o_s_tready   = 1'b0;
        case (r_state)
            hcm_pkg::ST_IDLE: begin
                o_s_tready   = 1'b1;
                o_cmd.accept = i_s_tvalid;
                if (i_s_tvalid) begin
                    n_state = hcm_pkg::ST_EVAL;
                end
            end
            hcm_pkg::ST_EVAL: begin
                // result lands once the output register is free or draining
                if (!r_out_vld || i_m_tready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = hcm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = hcm_pkg::ST_IDLE;
            end
        endcase

        // output register occupancy
        if (o_cmd.commit) begin
            n_out_vld = 1'b1;
        end else if (i_m_tready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    assign o_m_tvalid = r_out_vld;

endmodule

// File: src/hcm_store.sv
// allowlist byte store: one bank per slot, one write and one read port each
// depends on nothing; read data is registered

module hcm_store #(
    parameter int NSLOT       = 8,
    parameter int ENTRY_BYTES = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rd_en,
    input  logic [$clog2(ENTRY_BYTES)-1:0]    i_rd_addr,
    input  logic [NSLOT-1:0]                  i_wr_en,
    input  logic [$clog2(ENTRY_BYTES)-1:0]    i_wr_addr,
    input  logic [7:0]                        i_wr_data,
    output logic [NSLOT-1:0][7:0]             o_rd_data
);

    for (genvar g = 0; g < NSLOT; g++) begin : g_bank
        logic [7:0] r_mem [ENTRY_BYTES];
        logic [7:0] r_rd;

        // bank write
        always_ff @(posedge i_clk) begin
            if (i_wr_en[g]) begin
                r_mem[i_wr_addr] <= i_wr_data;
            end
        end

        // bank read, all banks at the same position
        always_ff @(posedge i_clk) begin
            if (i_rd_en) begin
                r_rd <= r_mem[i_rd_addr];
            end
        end

        assign o_rd_data[g] = r_rd;
    end

endmodule

// File: src/hcm_dp.sv
// datapath: byte classification, per-string parse state, slot table,
// allowlist compare and output register; depends on hcm_pkg and hcm_store

module hcm_dp #(
    parameter int LIST_ENTRIES = 8,
    parameter int ENTRY_BYTES  = 256,
    parameter int MAX_NAME     = 253,
    parameter int MAX_LABEL    = 63,
    parameter int MAX_V6       = 45
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hcm_pkg::t_dp_cmd  i_cmd,
    input  logic              i_cfg_we,
    input  logic [3:0]        i_cfg_wdata,
    input  logic              i_kind,
    input  logic [2:0]        i_slot,
    input  logic [7:0]        i_ch,
    input  logic              i_last,
    output logic [7:0]        o_out_ch,
    output logic              o_keep,
    output logic              o_done_res,
    output logic              o_valid_res,
    output logic              o_is_ipv6,
    output logic              o_listed
);

    localparam int NSLOT = (LIST_ENTRIES < 8) ? LIST_ENTRIES : 8;
    localparam int AW    = $clog2(ENTRY_BYTES);

    // character classes
    function automatic logic f_is_digit(input logic [7:0] c);
        f_is_digit = (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic f_is_hex(input logic [7:0] c);
        f_is_hex = f_is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) ||
                   ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic f_is_alnum(input logic [7:0] c);
        f_is_alnum = f_is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A)) ||
                     ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    // latched request
    logic       r_kind, r_last;
    logic [2:0] r_slot;
    logic [7:0] r_ch;

    // per-string state
    logic [8:0]       r_byte_count, n_byte_count;
    logic [7:0]       r_out_index, n_out_index;
    logic [6:0]       r_label_len, n_label_len;
    logic [1:0]       r_colon, n_colon;
    logic             r_flag_br, n_flag_br;
    logic             r_v6_ok, n_v6_ok;
    logic             r_dns_ok, n_dns_ok;
    logic [NSLOT-1:0] r_mism, n_mism;

    // slot table and configuration
    logic [NSLOT-1:0][7:0] r_ent_len;
    logic [NSLOT-1:0]      r_ent_vld;
    logic [3:0]            r_entry_count;

    // output register payload
    logic [7:0] r_o_ch;
    logic       r_o_keep, r_o_last, r_o_valid, r_o_v6, r_o_listed;

    // store interface
    logic [NSLOT-1:0]      s_wr_en;
    logic [NSLOT-1:0][7:0] s_rd_data;

    // per-byte decode
    logic       s_first, s_open_br, s_bracketed, s_v6mode, s_keep;
    logic [7:0] s_lo;
    logic       s_slot_ok, s_pos_ok, s_sat, s_valid, s_listed;
    logic [8:0] s_inner, s_nlen;

    hcm_store #(
        .NSLOT       (NSLOT),
        .ENTRY_BYTES (ENTRY_BYTES)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (i_cmd.accept),
        .i_rd_addr (r_out_index[AW-1:0]),
        .i_wr_en   (s_wr_en),
        .i_wr_addr (r_out_index[AW-1:0]),
        .i_wr_data (s_lo),
        .o_rd_data (s_rd_data)
    );

    // request latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind <= i_kind;
            r_slot <= i_slot;
            r_ch   <= i_ch;
            r_last <= i_last;
        end
    end

    // classification, string state update and verdict
    always_comb begin
        s_lo        = ((r_ch >= 8'h41) && (r_ch <= 8'h5A)) ? r_ch + 8'd32 : r_ch;
        s_first     = (r_byte_count == 9'd0);
        s_open_br   = s_first && (r_ch == hcm_pkg::CH_LBRACK);
        s_bracketed = r_last && r_flag_br && (r_ch == hcm_pkg::CH_RBRACK) && !s_first;
        s_v6mode    = r_last && (s_bracketed || (r_colon != 2'd0) ||
                                 (r_ch == hcm_pkg::CH_COLON));
        s_keep      = !s_open_br && !s_bracketed &&
                      !(r_last && !s_v6mode && (r_ch == hcm_pkg::CH_DOT));

        // ipv6 character check, bracket flag and colon count
        n_flag_br = r_flag_br || s_open_br;
        n_v6_ok   = r_v6_ok && (s_open_br || s_bracketed || f_is_hex(r_ch) ||
                                (r_ch == hcm_pkg::CH_COLON) || (r_ch == hcm_pkg::CH_DOT));
        n_colon   = ((r_ch == hcm_pkg::CH_COLON) && (r_colon < 2'd2)) ?
                    r_colon + 2'd1 : r_colon;

        // label tracking
        n_dns_ok    = r_dns_ok;
        n_label_len = r_label_len;
        if (r_ch == hcm_pkg::CH_DOT) begin
            if (r_label_len == 7'd0) begin
                n_dns_ok = 1'b0;
            end
            n_label_len = 7'd0;
        end else begin
            if (!(f_is_alnum(r_ch) || (r_ch == hcm_pkg::CH_DASH) ||
                  (r_ch == hcm_pkg::CH_USCORE))) begin
                n_dns_ok = 1'b0;
            end
            if (r_label_len >= 7'(MAX_LABEL)) begin
                n_dns_ok = 1'b0;
            end else begin
                n_label_len = r_label_len + 7'd1;
            end
        end

        n_byte_count = (r_byte_count < hcm_pkg::COUNT_SAT) ?
                       r_byte_count + 9'd1 : r_byte_count;
        s_sat        = (n_byte_count >= hcm_pkg::COUNT_SAT);

        // store write and allowlist compare at the current position
        s_slot_ok = ({4'd0, r_slot} < 7'(LIST_ENTRIES));
        s_pos_ok  = ({1'b0, r_out_index} < 9'(ENTRY_BYTES));
        n_mism    = r_mism;
        for (int i = 0; i < NSLOT; i++) begin
            s_wr_en[i] = i_cmd.commit && s_keep && (r_kind == hcm_pkg::KIND_LOAD) &&
                         s_slot_ok && s_pos_ok && (r_slot == 3'(i));
            if (s_keep && (r_kind == hcm_pkg::KIND_QUERY) &&
                ((r_out_index >= r_ent_len[i]) || !s_pos_ok || (s_rd_data[i] != s_lo))) begin
                n_mism[i] = 1'b1;
            end
        end
        n_out_index = (s_keep && (r_out_index < hcm_pkg::INDEX_SAT)) ?
                      r_out_index + 8'd1 : r_out_index;

        // verdict
        s_inner = s_bracketed ? n_byte_count - 9'd2 : n_byte_count;
        s_nlen  = (r_ch == hcm_pkg::CH_DOT) ? n_byte_count - 9'd1 : n_byte_count;
        if (s_v6mode) begin
            s_valid = !s_sat && n_v6_ok && (!n_flag_br || s_bracketed) &&
                      (n_colon >= 2'd2) && (s_inner <= 9'(MAX_V6));
        end else begin
            s_valid = r_last && !s_sat && n_dns_ok && (s_nlen >= 9'd1) &&
                      (s_nlen <= 9'(MAX_NAME));
        end

        // match against enabled, valid slots
        s_listed = 1'b0;
        for (int i = 0; i < NSLOT; i++) begin
            if ((4'(i) < r_entry_count) && r_ent_vld[i] && !n_mism[i] &&
                (r_ent_len[i] == n_out_index)) begin
                s_listed = 1'b1;
            end
        end
        s_listed = s_listed && r_last && s_valid && (r_kind == hcm_pkg::KIND_QUERY);
    end

    // per-string state, cleared after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= 9'd0;
            r_out_index  <= 8'd0;
            r_label_len  <= 7'd0;
            r_colon      <= 2'd0;
            r_flag_br    <= 1'b0;
            r_v6_ok      <= 1'b1;
            r_dns_ok     <= 1'b1;
            r_mism       <= '0;
        end else if (i_cmd.commit) begin
            if (r_last) begin
                r_byte_count <= 9'd0;
                r_out_index  <= 8'd0;
                r_label_len  <= 7'd0;
                r_colon      <= 2'd0;
                r_flag_br    <= 1'b0;
                r_v6_ok      <= 1'b1;
                r_dns_ok     <= 1'b1;
                r_mism       <= '0;
            end else begin
                r_byte_count <= n_byte_count;
                r_out_index  <= n_out_index;
                r_label_len  <= n_label_len;
                r_colon      <= n_colon;
                r_flag_br    <= n_flag_br;
                r_v6_ok      <= n_v6_ok;
                r_dns_ok     <= n_dns_ok;
                r_mism       <= n_mism;
            end
        end
    end

    // slot table, written at the end of a load string
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_len <= '0;
            r_ent_vld <= '0;
        end else if (i_cmd.commit && r_last && (r_kind == hcm_pkg::KIND_LOAD)) begin
            for (int i = 0; i < NSLOT; i++) begin
                if (s_slot_ok && (r_slot == 3'(i))) begin
                    r_ent_len[i] <= n_out_index;
                    r_ent_vld[i] <= s_valid && ({1'b0, n_out_index} <= 9'(ENTRY_BYTES));
                end
            end
        end
    end

    // entry count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= 4'd0;
        end else if (i_cfg_we) begin
            r_entry_count <= i_cfg_wdata;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_o_ch     <= s_lo;
            r_o_keep   <= s_keep;
            r_o_last   <= r_last;
            r_o_valid  <= r_last && s_valid;
            r_o_v6     <= s_v6mode;
            r_o_listed <= s_listed;
        end
    end

    assign o_out_ch    = r_o_ch;
    assign o_keep      = r_o_keep;
    assign o_done_res  = r_o_last;
    assign o_valid_res = r_o_valid;
    assign o_is_ipv6   = r_o_v6;
    assign o_listed    = r_o_listed;

endmodule

// File: src/hostname_canonicalize_and_match.sv
// Host canonicalizer and allowlist matcher. A byte request is accepted in the
// idle state, which reads every allowlist bank at the current canonical
// position, and finished in the evaluate state, which classifies the byte,
// compares, writes the load store and places the result in the output
// register; no new byte is taken before that, as the store read is registered.
// A result waiting in the output register does not block the next accept; the
// evaluate state waits only while that register is full. The store needs no
// clearing pass after reset. Write entry_count on i_cfg_we only while idle;
// the block does not enforce it. depends on hcm_pkg, hcm_ctrl, hcm_dp, hcm_store

module hostname_canonicalize_and_match #(
    parameter int LIST_ENTRIES = 8,
    parameter int ENTRY_BYTES  = 256,
    parameter int MAX_NAME     = 253,
    parameter int MAX_LABEL    = 63,
    parameter int MAX_V6       = 45
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [3:0]                    i_cfg_wdata,    // entry_count
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [hcm_pkg::TDATA_W-1:0]   s_axis_tdata,   // slot[2:0], ch[10:3]
    input  logic                          s_axis_tuser,   // kind
    input  logic                          s_axis_tlast,   // last
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [hcm_pkg::TDATA_W-1:0]   m_axis_tdata,   // out_ch[7:0], valid_res[8],
                                                          // is_ipv6[9], listed[10]
    output logic                          m_axis_tuser,   // keep
    output logic                          m_axis_tlast    // done_res
);

    hcm_pkg::t_dp_cmd s_cmd;
    logic [7:0]       s_out_ch;
    logic             s_valid_res, s_is_ipv6, s_listed;

    hcm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_cmd      (s_cmd)
    );

    hcm_dp #(
        .LIST_ENTRIES (LIST_ENTRIES),
        .ENTRY_BYTES  (ENTRY_BYTES),
        .MAX_NAME     (MAX_NAME),
        .MAX_LABEL    (MAX_LABEL),
        .MAX_V6       (MAX_V6)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (s_cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_kind      (s_axis_tuser),
        .i_slot      (s_axis_tdata[2:0]),
        .i_ch        (s_axis_tdata[10:3]),
        .i_last      (s_axis_tlast),
        .o_out_ch    (s_out_ch),
        .o_keep      (m_axis_tuser),
        .o_done_res  (m_axis_tlast),
        .o_valid_res (s_valid_res),
        .o_is_ipv6   (s_is_ipv6),
        .o_listed    (s_listed)
    );

    // result packing
    assign m_axis_tdata = {5'd0, s_listed, s_is_ipv6, s_valid_res, s_out_ch};

endmodule

// File: src/hcm_checker.sv
// port-level checks for the host canonicalizer and matcher, bound to the top
// depends on hostname_canonicalize_and_match

module hcm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // one request in flight: no accept in the cycle after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while previous one still evaluating");

    // verdict fields stay zero on results that are not final
    a_verdict_final_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[10:8] == 3'd0))
        else $error("verdict set on a non-final result");

    // a match is only reported for an acceptable host
    a_listed_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[10]) |-> m_axis_tdata[8])
        else $error("listed without valid verdict");

    // stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
         $stable(m_axis_tlast)))
        else $error("stalled result changed or dropped");

endmodule

bind hostname_canonicalize_and_match hcm_checker u_hcm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
